FILE: design/fdsa_pkg.sv
// Shared constants, codes and handshake structs for the Forth data stack ALU.
package fdsa_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int LIT_W       = 32;
  localparam int EMIT_W      = 32;
  localparam int DEPTH_W     = 7;
  localparam int OPCODE_W    = 4;
  localparam int STATUS_W    = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH = 4'd0,
    OP_DUP  = 4'd1,
    OP_DROP = 4'd2,
    OP_SWAP = 4'd3,
    OP_DOT  = 4'd4,
    OP_ADD  = 4'd5,
    OP_SUB  = 4'd6,
    OP_MUL  = 4'd7,
    OP_DIV  = 4'd8,
    OP_EQ   = 4'd9,
    OP_LT   = 4'd10,
    OP_GT   = 4'd11
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIV_ZERO  = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
  } sts_t;

endpackage

FILE: design/fdsa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module fdsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/fdsa_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module fdsa_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [fdsa_pkg::DATA_WIDTH-1:0]  dividend,
  input  logic [fdsa_pkg::DATA_WIDTH-1:0]  divisor,
  output logic                             busy,
  output logic [fdsa_pkg::DATA_WIDTH-1:0]  quotient
);
  import fdsa_pkg::*;

  localparam int IT_W = $clog2(DATA_WIDTH + 1);

  logic                  busy_r, busy_nxt;
  logic [IT_W-1:0]       iter_r, iter_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] dvs_r, dvs_nxt;
  logic                  neg_r, neg_nxt;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   trial;
  logic                  n_neg, d_neg;

  assign n_neg = dividend[DATA_WIDTH-1];
  assign d_neg = divisor[DATA_WIDTH-1];

  always_comb begin
    busy_nxt = busy_r;
    iter_nxt = iter_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    shifted  = {rem_r, quo_r[DATA_WIDTH-1]};
    trial    = shifted - {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      iter_nxt = IT_W'(DATA_WIDTH);
      rem_nxt  = '0;
      quo_nxt  = n_neg ? (DATA_WIDTH'(0) - dividend) : dividend;
      dvs_nxt  = d_neg ? (DATA_WIDTH'(0) - divisor) : divisor;
      neg_nxt  = n_neg ^ d_neg;
    end else if (busy_r) begin
      if (!trial[DATA_WIDTH]) begin
        rem_nxt = trial[DATA_WIDTH-1:0];
      end else begin
        rem_nxt = shifted[DATA_WIDTH-1:0];
      end
      quo_nxt  = {quo_r[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
      iter_nxt = iter_r - IT_W'(1);
      if (iter_r == IT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      iter_r <= iter_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? (DATA_WIDTH'(0) - quo_r) : quo_r;

endmodule

FILE: design/fdsa_dpath.sv
// Datapath: top-of-stack register, stack RAM, ALU, divider and result registers.
module fdsa_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fdsa_pkg::cmd_t                 cmd,
  output fdsa_pkg::sts_t                 sts,
  input  logic [fdsa_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic signed [fdsa_pkg::LIT_W-1:0] in_literal,
  output logic [fdsa_pkg::STATUS_W-1:0]  out_status,
  output logic                           out_emit_valid,
  output logic signed [fdsa_pkg::EMIT_W-1:0] out_emit_value,
  output logic [fdsa_pkg::DEPTH_W-1:0]   out_depth
);
  import fdsa_pkg::*;

  opcode_t               op_r;
  logic [DATA_WIDTH-1:0] lit_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [DATA_WIDTH-1:0] tos_r, tos_nxt;
  status_t               status_nxt;
  logic                  emit_nxt;
  logic [DATA_WIDTH-1:0] nxt;
  logic [DATA_WIDTH-1:0] alu;
  logic [DATA_WIDTH-1:0] quotient;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [ADDR_W-1:0]     mem_raddr;
  logic                  mem_we;
  logic                  has1, has2, full;
  logic                  div_busy;

  assign has1 = (count_r != '0);
  assign has2 = (count_r >= CNT_W'(2));
  assign full = (count_r == CNT_W'(STACK_DEPTH));
  assign mem_raddr = ADDR_W'(count_r - CNT_W'(2));

  fdsa_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we & cmd.commit),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (nxt)
  );

  fdsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (nxt),
    .divisor  (tos_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign sts.need_div = (op_r == OP_DIV) && has2 && (tos_r != '0);
  assign sts.div_busy = div_busy;

  always_comb begin
    case (op_r)
      OP_ADD:  alu = nxt + tos_r;
      OP_SUB:  alu = nxt - tos_r;
      OP_MUL:  alu = nxt * tos_r;
      OP_DIV:  alu = quotient;
      OP_EQ:   alu = {{(DATA_WIDTH-1){1'b0}}, nxt == tos_r};
      OP_LT:   alu = {{(DATA_WIDTH-1){1'b0}}, $signed(nxt) < $signed(tos_r)};
      default: alu = {{(DATA_WIDTH-1){1'b0}}, $signed(tos_r) < $signed(nxt)};
    endcase
  end

  always_comb begin
    status_nxt = ST_OK;
    emit_nxt   = 1'b0;
    count_nxt  = count_r;
    tos_nxt    = tos_r;
    mem_we     = 1'b0;
    mem_waddr  = ADDR_W'(count_r - CNT_W'(1));
    mem_wdata  = tos_r;
    unique case (op_r) inside
      OP_PUSH: begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          mem_we    = has1;
          tos_nxt   = lit_r;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DUP: begin
        if (!has1) begin
          status_nxt = ST_UNDERFLOW;
        end else if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          mem_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DROP: begin
        if (!has1) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          tos_nxt   = nxt;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_SWAP: begin
        if (!has2) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = mem_raddr;
          tos_nxt   = nxt;
        end
      end
      OP_DOT: begin
        if (!has1) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          emit_nxt  = 1'b1;
          tos_nxt   = nxt;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT, OP_GT: begin
        if (!has2) begin
          status_nxt = ST_UNDERFLOW;
        end else if ((op_r == OP_DIV) && (tos_r == '0)) begin
          status_nxt = ST_DIV_ZERO;
        end else begin
          tos_nxt   = alu;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
    if (cmd.load) begin
      op_r  <= opcode_t'(in_opcode);
      lit_r <= DATA_WIDTH'(in_literal);
    end
    if (cmd.commit) begin
      tos_r          <= tos_nxt;
      out_status     <= status_nxt;
      out_emit_valid <= emit_nxt;
      out_emit_value <= emit_nxt ? EMIT_W'(tos_r) : '0;
      out_depth      <= DEPTH_W'(count_nxt);
    end
  end

endmodule

FILE: design/fdsa_ctrl.sv
// Controller: sequences accept, execute, divide and result handoff.
module fdsa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  fdsa_pkg::sts_t sts,
  output fdsa_pkg::cmd_t cmd
);
  import fdsa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: design/forth_data_stack_alu.sv
// Top level of the Forth data stack with an integer ALU.
// The result is registered when the request commits from the execute state; a divide
// with two operands and a nonzero divisor first runs the one-bit-per-cycle divider and
// commits from the done state. Commit waits while an earlier result is held. Requests
// are handled one at a time. A new request is accepted while an earlier result waits.
// Synchronous active-low reset empties the stack; stack RAM contents are not cleared.
module forth_data_stack_alu (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fdsa_pkg::OPCODE_W-1:0]     in_opcode,
  input  logic signed [fdsa_pkg::LIT_W-1:0] in_literal,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fdsa_pkg::STATUS_W-1:0]     out_status,
  output logic                              out_emit_valid,
  output logic signed [fdsa_pkg::EMIT_W-1:0] out_emit_value,
  output logic [fdsa_pkg::DEPTH_W-1:0]      out_depth
);
  import fdsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fdsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fdsa_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_opcode),
    .in_literal     (in_literal),
    .out_status     (out_status),
    .out_emit_valid (out_emit_valid),
    .out_emit_value (out_emit_value),
    .out_depth      (out_depth)
  );

  // A request is never followed by another in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  // An emitted value always comes with an ok status.
  a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_emit_valid |-> out_status == ST_OK)
    else $error("emit reported with a failing status");

  // The reported depth never exceeds the stack size.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_depth <= DEPTH_W'(STACK_DEPTH))
    else $error("depth beyond stack size");

  // No result can appear in the cycle after a request is accepted.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result produced too early");

endmodule

FILE: verif/tb_forth_data_stack_alu.sv
// Self-checking testbench for the Forth data stack ALU with a predictor and random stalls.
module tb_forth_data_stack_alu;
  import fdsa_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_NOP_FIRST = 4'd12;
  localparam logic [OPCODE_W-1:0] OP_NOP_LAST  = 4'd15;
  localparam logic signed [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam int RANDOM_REQUESTS = 1750;
  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_CYCLES    = DATA_WIDTH + 8;
  localparam int LONG_HOLD       = 300;

  typedef struct packed {
    logic [OPCODE_W-1:0]     opcode;
    logic signed [LIT_W-1:0] literal;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                emit_valid;
    logic [EMIT_W-1:0]   emit_value;
    logic [DEPTH_W-1:0]  depth;
  } stack_reply_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [OPCODE_W-1:0]      in_opcode = '0;
  logic signed [LIT_W-1:0]  in_literal = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic                     out_emit_valid;
  logic signed [EMIT_W-1:0] out_emit_value;
  logic [DEPTH_W-1:0]       out_depth;

  request_t     request_q[$];
  stack_reply_t predicted_replies[$];

  logic signed [DATA_WIDTH-1:0] word_stack [STACK_DEPTH];
  int  word_count = 0;
  int  depth_estimate = 0;
  int  error_count = 0;
  int  replies_seen = 0;
  logic in_fire = 1'b0;

  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int next_hold_at = 400;
  int mode_left = 0;
  int stall_mode = 0;
  int stall_phase = 0;
  int idle_cycles = 0;

  forth_data_stack_alu u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_literal     (in_literal),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_emit_valid (out_emit_valid),
    .out_emit_value (out_emit_value),
    .out_depth      (out_depth)
  );

  always #10 clk = ~clk;

  function automatic stack_reply_t execute_opcode(input logic [OPCODE_W-1:0] op,
                                                  input logic signed [LIT_W-1:0] lit);
    stack_reply_t                 res;
    logic signed [DATA_WIDTH-1:0] top;
    logic signed [DATA_WIDTH-1:0] nxt;
    logic signed [DATA_WIDTH-1:0] val;
    res = '0;
    top = '0;
    nxt = '0;
    val = '0;
    if (word_count >= 2) begin
      top = word_stack[word_count-1];
      nxt = word_stack[word_count-2];
    end
    case (op) inside
      OP_PUSH: begin
        if (word_count >= STACK_DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          word_stack[word_count] = lit;
          word_count++;
        end
      end
      OP_DUP: begin
        if (word_count < 1) begin
          res.status = ST_UNDERFLOW;
        end else if (word_count >= STACK_DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          word_stack[word_count] = word_stack[word_count-1];
          word_count++;
        end
      end
      OP_DROP: begin
        if (word_count < 1) res.status = ST_UNDERFLOW;
        else word_count--;
      end
      OP_SWAP: begin
        if (word_count < 2) begin
          res.status = ST_UNDERFLOW;
        end else begin
          word_stack[word_count-1] = nxt;
          word_stack[word_count-2] = top;
        end
      end
      OP_DOT: begin
        if (word_count < 1) begin
          res.status = ST_UNDERFLOW;
        end else begin
          word_count--;
          res.emit_valid = 1'b1;
          res.emit_value = word_stack[word_count];
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT, OP_GT: begin
        if (word_count < 2) begin
          res.status = ST_UNDERFLOW;
        end else if (op == OP_DIV && top == 0) begin
          res.status = ST_DIV_ZERO;
        end else begin
          case (op)
            OP_ADD: val = nxt + top;
            OP_SUB: val = nxt - top;
            OP_MUL: val = nxt * top;
            OP_DIV: begin
              // The one quotient that does not fit wraps back to the most negative word.
              if (nxt == MOST_NEG && top == -1) val = MOST_NEG;
              else val = nxt / top;
            end
            OP_EQ:  val = (nxt == top) ? 1 : 0;
            OP_LT:  val = (nxt < top) ? 1 : 0;
            default: val = (nxt > top) ? 1 : 0;
          endcase
          word_count--;
          word_stack[word_count-1] = val;
        end
      end
      default: ;
    endcase
    res.depth = DEPTH_W'(word_count);
    return res;
  endfunction

  task automatic queue_request(input logic [OPCODE_W-1:0] op,
                               input logic signed [LIT_W-1:0] lit);
    request_t req;
    req.opcode  = op;
    req.literal = lit;
    request_q.push_back(req);
    case (op) inside
      OP_PUSH: if (depth_estimate < STACK_DEPTH) depth_estimate++;
      OP_DUP: if (depth_estimate > 0 && depth_estimate < STACK_DEPTH) depth_estimate++;
      OP_DROP, OP_DOT: if (depth_estimate > 0) depth_estimate--;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT, OP_GT:
        if (depth_estimate >= 2) depth_estimate--;
      default: ;
    endcase
  endtask

  function automatic logic signed [LIT_W-1:0] pick_literal();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      return $urandom_range(0, 10) - 5;
    end else if (sel < 55) begin
      case ($urandom_range(0, 4))
        0: return MOST_NEG;
        1: return MOST_POS;
        2: return 0;
        3: return -1;
        default: return 1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_consumer();
    case ($urandom_range(0, 8))
      0: return OP_DROP;
      1: return OP_DOT;
      2: return OP_ADD;
      3: return OP_SUB;
      4: return OP_MUL;
      5: return OP_DIV;
      6: return OP_EQ;
      7: return OP_LT;
      default: return OP_GT;
    endcase
  endfunction

  task automatic check_reply(input stack_reply_t got);
    stack_reply_t want;
    if (predicted_replies.size() == 0) begin
      $error("unexpected reply: status %0d depth %0d", got.status, got.depth);
      error_count++;
      return;
    end
    want = predicted_replies.pop_front();
    if (got.status !== want.status) begin
      $error("out_status mismatch: expected %0d, actual %0d", want.status, got.status);
      error_count++;
    end
    if (got.emit_valid !== want.emit_valid) begin
      $error("out_emit_valid mismatch: expected %0d, actual %0d",
             want.emit_valid, got.emit_valid);
      error_count++;
    end
    if (got.emit_value !== want.emit_value) begin
      $error("out_emit_value mismatch: expected %0d, actual %0d",
             $signed(want.emit_value), $signed(got.emit_value));
      error_count++;
    end
    if (got.depth !== want.depth) begin
      $error("out_depth mismatch: expected %0d, actual %0d", want.depth, got.depth);
      error_count++;
    end
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin : request_driver
    request_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (request_q.size() > 0) begin
      req = request_q.pop_front();
      in_valid   <= 1'b1;
      in_opcode  <= req.opcode;
      in_literal <= req.literal;
      if (burst_left > 0) begin
        burst_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        gap_left   = 0;
        burst_left = $urandom_range(30, 120);
      end else begin
        gap_left   = ($urandom_range(0, 9) == 0) ? 20 : $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Reply sink: stall modes change over time, with a long hold-off now and then.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (replies_seen >= next_hold_at) begin
      out_ready <= 1'b0;
      hold_left = LONG_HOLD;
      next_hold_at += 800;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(40, 250);
      end
      mode_left--;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_ready <= (stall_phase == 0);
          stall_phase = (stall_phase + 1) % 3;
        end
      endcase
    end
  end

  always @(posedge clk) begin : monitor
    stack_reply_t got;
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.status     = out_status;
        got.emit_valid = out_emit_valid;
        got.emit_value = out_emit_value;
        got.depth      = out_depth;
        check_reply(got);
        replies_seen++;
      end
      if (in_valid && in_ready) predicted_replies.push_back(execute_opcode(in_opcode, in_literal));
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int made;
    int phase_left;
    int phase_kind;
    logic [OPCODE_W-1:0] op;
    made       = 0;
    phase_left = 0;
    phase_kind = 0;

    queue_request(OP_DROP, 0);
    queue_request(OP_DOT, 0);
    queue_request(OP_DUP, 0);
    queue_request(OP_PUSH, MOST_NEG);
    queue_request(OP_SWAP, 0);
    queue_request(OP_ADD, 0);
    queue_request(OP_PUSH, -1);
    queue_request(OP_DIV, 0);
    queue_request(OP_PUSH, MOST_POS);
    queue_request(OP_PUSH, 0);
    queue_request(OP_DIV, 0);
    queue_request(OP_DROP, 0);
    queue_request(OP_ADD, 0);
    queue_request(OP_PUSH, -7);
    queue_request(OP_PUSH, 2);
    queue_request(OP_DIV, MOST_NEG);
    queue_request(OP_SWAP, 0);
    queue_request(OP_SUB, 0);
    queue_request(OP_DUP, 0);
    queue_request(OP_EQ, 0);
    queue_request(OP_PUSH, MOST_POS);
    queue_request(OP_MUL, 0);
    queue_request(OP_PUSH, MOST_NEG);
    queue_request(OP_LT, 0);
    queue_request(OP_PUSH, 5);
    queue_request(OP_GT, -1);
    queue_request(OP_DOT, 0);
    queue_request(OP_NOP_FIRST, -1);
    queue_request(OP_NOP_LAST, MOST_POS);

    // Fill phases run the stack into overflow, drain phases into underflow.
    while (made < RANDOM_REQUESTS) begin
      if (phase_left == 0) begin
        phase_kind = $urandom_range(0, 2);
        phase_left = $urandom_range(10, 100);
      end
      phase_left--;
      case (phase_kind)
        0: begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: op = OP_PUSH;
            6, 7: op = OP_DUP;
            default: op = OPCODE_W'($urandom_range(1, 11));
          endcase
        end
        1: begin
          if (depth_estimate < 2 && $urandom_range(0, 2) == 0) op = OP_PUSH;
          else if ($urandom_range(0, 9) < 7) op = pick_consumer();
          else op = OPCODE_W'($urandom_range(1, 11));
        end
        default: begin
          if ($urandom_range(0, 99) < 3) begin
            op = OPCODE_W'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
          end else if ($urandom_range(0, 99) < 35) begin
            op = OP_PUSH;
          end else begin
            op = OPCODE_W'($urandom_range(1, 11));
          end
        end
      endcase
      queue_request(op, pick_literal());
      if (op < OP_NOP_FIRST) made++;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || in_valid || predicted_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: forth_data_stack_alu.f
design/fdsa_pkg.sv
design/fdsa_ram.sv
design/fdsa_div.sv
design/fdsa_dpath.sv
design/fdsa_ctrl.sv
design/forth_data_stack_alu.sv
verif/tb_forth_data_stack_alu.sv
